// ===== rtl/core/pba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pba_pkg;

    localparam int MAP_BITS = 32;
    localparam logic [31:0] MIN_MEMORY_BYTES = 32'd8388608;

    // request kinds carried on s_tuser
    localparam logic [1:0] REQ_INIT  = 2'd0;
    localparam logic [1:0] REQ_ALLOC = 2'd1;
    localparam logic [1:0] REQ_FREE  = 2'd2;

    // configuration register indexes
    localparam logic CFG_MEMORY_BYTES   = 1'b0;
    localparam logic CFG_RESERVED_PAGES = 1'b1;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NOT_READY    = 3'd1,
        ST_TOO_SMALL    = 3'd2,
        ST_NONE_FREE    = 3'd3,
        ST_NULL_ADDR    = 3'd4,
        ST_RANGE        = 3'd5,
        ST_ALREADY_FREE = 3'd6
    } status_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] alloc_address;
        logic [15:0] total_pages;
        logic [15:0] used_pages;
        logic [15:0] free_pages;
        logic        ready_res;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/pba_map_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pba_map_ram #(
    parameter int WORDS  = 1024,
    parameter int ADDR_W = 10
) (
    input  wire                aclk,
    input  wire                wr_en,
    input  wire [ADDR_W-1:0]   wr_addr,
    input  wire [31:0]         wr_data,
    input  wire                rd_en,
    input  wire [ADDR_W-1:0]   rd_addr,
    output logic [31:0]        rd_data
);

    logic [31:0] mem [WORDS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/pba_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pba_ctrl #(
    parameter int MAX_PAGES  = 32768,
    parameter int PAGE_BYTES = 4096
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  req_valid,
    output logic                 req_ready,
    input  wire [1:0]            req_type,
    input  wire [31:0]           page_address,
    input  wire [31:0]           memory_bytes,
    input  wire [15:0]           reserved_pages,
    output logic                 res_valid,
    input  wire                  res_ready,
    output pba_pkg::result_t     res
);

    localparam int MAP_WORDS  = (MAX_PAGES + pba_pkg::MAP_BITS - 1) / pba_pkg::MAP_BITS;
    localparam int WORD_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int CNT_W      = $clog2(MAX_PAGES + 1);
    localparam int PW         = WORD_W + 5;
    localparam int FP_W       = 32 - PAGE_SHIFT;
    localparam int EXT_A      = (PW > CNT_W) ? PW : CNT_W;
    localparam int EXT_B      = (FP_W > 16) ? FP_W : 16;
    localparam int EXT_W      = ((EXT_A > EXT_B) ? EXT_A : EXT_B) + 1;
    localparam logic [WORD_W-1:0] LAST_MAP_WORD = WORD_W'(MAP_WORDS - 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_INIT  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_FREE  = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     page_count_reg, page_count_next;
    logic [CNT_W-1:0]     used_count_reg, used_count_next;
    logic [CNT_W-1:0]     reserved_count_reg, reserved_count_next;
    logic                 is_ready_reg, is_ready_next;
    logic [2:0]           status_reg, status_next;
    logic [31:0]          addr_reg, addr_next;
    logic [WORD_W:0]      issue_word_reg, issue_word_next;
    logic [WORD_W-1:0]    chk_word_reg, chk_word_next;
    logic                 chk_valid_reg, chk_valid_next;
    logic [WORD_W-1:0]    init_word_reg, init_word_next;
    logic [4:0]           free_bit_reg, free_bit_next;
    logic [PW-1:0]        free_page_reg;

    logic                 wr_en, rd_en;
    logic [WORD_W-1:0]    wr_addr, rd_addr;
    logic [31:0]          wr_data, rd_data;

    logic [EXT_W-1:0]     tot_ext, res_ext, fp_ext, pc_m1;
    logic [WORD_W-1:0]    last_word;
    logic [31:0]          init_mask, scan_occ, free_bits, lowest;
    logic [4:0]           low_idx;
    logic [PW-1:0]        found_page;

    // bits of word w that lie outside [lo, hi) read as occupied
    function automatic logic [31:0] occ_mask(input logic [WORD_W-1:0] w,
                                             input logic [CNT_W-1:0] lo,
                                             input logic [CNT_W-1:0] hi);
        logic [31:0]      m;
        logic [EXT_W-1:0] p;
        m = '0;
        for (int b = 0; b < 32; b++) begin
            p = EXT_W'({w, 5'(b)});
            m[b] = (p < EXT_W'(lo)) || (p >= EXT_W'(hi));
        end
        return m;
    endfunction

    pba_map_ram #(
        .WORDS  (MAP_WORDS),
        .ADDR_W (WORD_W)
    ) u_map (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        tot_ext = EXT_W'(memory_bytes >> PAGE_SHIFT);
        if (tot_ext > EXT_W'(MAX_PAGES)) begin
            tot_ext = EXT_W'(MAX_PAGES);
        end
        res_ext = EXT_W'(reserved_pages);
        if (res_ext > tot_ext) begin
            res_ext = tot_ext;
        end
        fp_ext    = EXT_W'(page_address >> PAGE_SHIFT);
        pc_m1     = EXT_W'(page_count_reg) - EXT_W'(1);
        last_word = pc_m1[PW-1:5];
        init_mask = occ_mask(init_word_reg, reserved_count_reg, page_count_reg);
        scan_occ  = rd_data | occ_mask(chk_word_reg, reserved_count_reg, page_count_reg);
        free_bits = ~scan_occ;
        lowest    = free_bits & (~free_bits + 32'd1);
        low_idx   = '0;
        for (int b = 0; b < 32; b++) begin
            if (lowest[b]) begin
                low_idx = low_idx | 5'(b);
            end
        end
        found_page = {chk_word_reg, low_idx};
    end

    always_comb begin
        state_next          = state_reg;
        page_count_next     = page_count_reg;
        used_count_next     = used_count_reg;
        reserved_count_next = reserved_count_reg;
        is_ready_next       = is_ready_reg;
        status_next         = status_reg;
        addr_next           = addr_reg;
        issue_word_next     = issue_word_reg;
        chk_word_next       = chk_word_reg;
        chk_valid_next      = 1'b0;
        init_word_next      = init_word_reg;
        free_bit_next       = free_bit_reg;
        wr_en               = 1'b0;
        wr_addr             = init_word_reg;
        wr_data             = init_mask;
        rd_en               = 1'b0;
        rd_addr             = fp_ext[PW-1:5];
        req_ready           = (state_reg == S_IDLE);
        res_valid           = (state_reg == S_RESP);

        case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    status_next = pba_pkg::ST_OK;
                    addr_next   = '0;
                    state_next  = S_RESP;
                    if (req_type == pba_pkg::REQ_INIT) begin
                        if (memory_bytes < pba_pkg::MIN_MEMORY_BYTES) begin
                            status_next = pba_pkg::ST_TOO_SMALL;
                        end else begin
                            page_count_next     = CNT_W'(tot_ext);
                            reserved_count_next = CNT_W'(res_ext);
                            used_count_next     = CNT_W'(res_ext);
                            is_ready_next       = 1'b1;
                            init_word_next      = '0;
                            state_next          = S_INIT;
                        end
                    end else if (!is_ready_reg) begin
                        status_next = pba_pkg::ST_NOT_READY;
                    end else if (req_type == pba_pkg::REQ_ALLOC) begin
                        if (used_count_reg >= page_count_reg ||
                            reserved_count_reg >= page_count_reg) begin
                            status_next = pba_pkg::ST_NONE_FREE;
                        end else begin
                            issue_word_next = {1'b0, reserved_count_reg[PW-1:5]};
                            state_next      = S_SCAN;
                        end
                    end else if (req_type == pba_pkg::REQ_FREE) begin
                        if (page_address == 32'd0) begin
                            status_next = pba_pkg::ST_NULL_ADDR;
                        end else if (fp_ext >= EXT_W'(page_count_reg)) begin
                            status_next = pba_pkg::ST_RANGE;
                        end else begin
                            rd_en         = 1'b1;
                            free_bit_next = fp_ext[4:0];
                            state_next    = S_FREE;
                        end
                    end
                end
            end
            S_INIT: begin
                wr_en          = 1'b1;
                init_word_next = init_word_reg + WORD_W'(1);
                if (init_word_reg == LAST_MAP_WORD) begin
                    state_next = S_RESP;
                end
            end
            S_SCAN: begin
                // issue the next word while the previous one is checked
                if (issue_word_reg <= {1'b0, last_word}) begin
                    rd_en           = 1'b1;
                    rd_addr         = issue_word_reg[WORD_W-1:0];
                    issue_word_next = issue_word_reg + (WORD_W + 1)'(1);
                    chk_valid_next  = 1'b1;
                    chk_word_next   = issue_word_reg[WORD_W-1:0];
                end
                if (chk_valid_reg) begin
                    if (|free_bits) begin
                        wr_en           = 1'b1;
                        wr_addr         = chk_word_reg;
                        wr_data         = rd_data | lowest;
                        used_count_next = used_count_reg + CNT_W'(1);
                        addr_next       = 32'(64'(found_page) << PAGE_SHIFT);
                        status_next     = pba_pkg::ST_OK;
                        state_next      = S_RESP;
                    end else if (chk_word_reg == last_word) begin
                        status_next = pba_pkg::ST_NONE_FREE;
                        state_next  = S_RESP;
                    end
                end
            end
            S_FREE: begin
                state_next = S_RESP;
                if (!rd_data[free_bit_reg]) begin
                    status_next = pba_pkg::ST_ALREADY_FREE;
                end else begin
                    wr_en           = 1'b1;
                    wr_addr         = free_page_reg[PW-1:5];
                    wr_data         = rd_data & ~(32'd1 << free_bit_reg);
                    used_count_next = used_count_reg - CNT_W'(1);
                end
            end
            S_RESP: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // free address stays on the input port only while accepting; hold it
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE) begin
            free_page_reg <= fp_ext[PW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= S_IDLE;
            page_count_reg     <= '0;
            used_count_reg     <= '0;
            reserved_count_reg <= '0;
            is_ready_reg       <= 1'b0;
            chk_valid_reg      <= 1'b0;
        end else begin
            state_reg          <= state_next;
            page_count_reg     <= page_count_next;
            used_count_reg     <= used_count_next;
            reserved_count_reg <= reserved_count_next;
            is_ready_reg       <= is_ready_next;
            chk_valid_reg      <= chk_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg     <= status_next;
        addr_reg       <= addr_next;
        issue_word_reg <= issue_word_next;
        chk_word_reg   <= chk_word_next;
        init_word_reg  <= init_word_next;
        free_bit_reg   <= free_bit_next;
    end

    always_comb begin
        res.status        = status_reg;
        res.alloc_address = addr_reg;
        res.total_pages   = is_ready_reg ? 16'(page_count_reg) : 16'd0;
        res.used_pages    = is_ready_reg ? 16'(used_count_reg) : 16'd0;
        res.free_pages    = is_ready_reg ? 16'(page_count_reg - used_count_reg) : 16'd0;
        res.ready_res     = is_ready_reg;
    end

    a_used_le_total: assert property (@(posedge aclk) disable iff (!aresetn)
        used_count_reg <= page_count_reg)
        else $error("used page count exceeds page count");

    a_reserved_le_total: assert property (@(posedge aclk) disable iff (!aresetn)
        reserved_count_reg <= page_count_reg)
        else $error("reserved count exceeds page count");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE || state_reg == S_RESP) |-> !wr_en)
        else $error("map written outside a request");

    a_resp_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_ready) |=> (state_reg == S_IDLE))
        else $error("engine did not return to idle after result");

    a_free_page_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FREE) |-> (free_page_reg[4:0] == free_bit_reg))
        else $error("free bit index lost");

endmodule

`default_nettype wire

// ===== rtl/core/page_bitmap_allocator.sv =====
// Init writes every map word, one map word per cycle; alloc scans map words starting
// from the word that holds the reserved count; free of an in-range page reads and
// rewrites its map word; rejects and the spare code are answered without the map.
// Throughput: one request at a time, the next beat not taken until the last result
// has left the controller.
// Reset (aresetn low, synchronous): not ready, counts and config cleared.
`timescale 1ns / 1ps
`default_nettype none

module page_bitmap_allocator #(
    parameter int MAX_PAGES  = 32768,
    parameter int PAGE_BYTES = 4096
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [31:0]  s_tdata,   // [31:0] page_address
    input  wire [1:0]   s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [87:0] m_tdata,   // [31:0] alloc_address, [47:32] total_pages,
                                   // [63:48] used_pages, [79:64] free_pages,
                                   // [80] ready_res, [87:81] zero
    output logic [2:0]  m_tuser,   // [2:0] status
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire         cfg_index,
    input  wire [31:0]  cfg_data
);

    logic [31:0]       memory_bytes_reg;
    logic [15:0]       reserved_pages_reg;
    logic              res_valid, res_ready;
    pba_pkg::result_t  res;
    pba_pkg::result_t  out_reg;
    logic              m_tvalid_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            memory_bytes_reg   <= '0;
            reserved_pages_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                pba_pkg::CFG_MEMORY_BYTES:   memory_bytes_reg   <= cfg_data;
                pba_pkg::CFG_RESERVED_PAGES: reserved_pages_reg <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    pba_ctrl #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .req_valid      (s_tvalid),
        .req_ready      (s_tready),
        .req_type       (s_tuser),
        .page_address   (s_tdata),
        .memory_bytes   (memory_bytes_reg),
        .reserved_pages (reserved_pages_reg),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {7'd0, out_reg.ready_res, out_reg.free_pages, out_reg.used_pages,
                       out_reg.total_pages, out_reg.alloc_address};

endmodule

`default_nettype wire

// ===== dv/page_bitmap_allocator_tb.sv =====
`timescale 1ns / 1ps

module page_bitmap_allocator_tb;

    localparam int MAX_PAGES    = 32768;
    localparam int PAGE_BYTES   = 4096;
    localparam int IDLE_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 50;
    localparam int RANDOM_ITEMS = 1100;
    localparam int PRINT_LIMIT  = 50;
    localparam logic [1:0]  REQ_SPARE = 2'd3;
    localparam logic [31:0] ADDR_TOP  = 32'hFFFF_FFFF;

    // page map mirror plus the queue of results still owed by the block
    class page_map_scoreboard;
        bit                occupied [MAX_PAGES];
        int unsigned       page_total;
        int unsigned       page_used;
        int unsigned       page_floor;
        bit                map_ready;
        logic [31:0]       mem_reg;
        logic [15:0]       floor_reg;
        pba_pkg::result_t  owed_q [$];
        int                errors;

        task report(string what);
            if (errors < PRINT_LIMIT)
                $display("%0t ERROR %s", $time, what);
            errors++;
        endtask

        function void write_reg(logic idx, logic [31:0] data);
            if (idx == pba_pkg::CFG_MEMORY_BYTES)
                mem_reg = data;
            else
                floor_reg = data[15:0];
        endfunction

        function pba_pkg::result_t note_request(logic [1:0] kind, logic [31:0] addr);
            pba_pkg::result_t r;
            pba_pkg::status_t st;
            int unsigned      pg;
            int unsigned      n;
            logic [31:0]      granted;
            st = pba_pkg::ST_OK;
            granted = '0;
            if (kind == pba_pkg::REQ_INIT) begin
                if (mem_reg < pba_pkg::MIN_MEMORY_BYTES) begin
                    st = pba_pkg::ST_TOO_SMALL;
                end else begin
                    n = mem_reg / PAGE_BYTES;
                    if (n > MAX_PAGES)
                        n = MAX_PAGES;
                    page_total = n;
                    page_floor = (floor_reg < n) ? floor_reg : n;
                    for (pg = 0; pg < MAX_PAGES; pg++)
                        occupied[pg] = (pg < page_floor) || (pg >= n);
                    page_used = page_floor;
                    map_ready = 1'b1;
                end
            end else if (!map_ready) begin
                st = pba_pkg::ST_NOT_READY;
            end else if (kind == pba_pkg::REQ_ALLOC) begin
                st = pba_pkg::ST_NONE_FREE;
                // first fit from the reserved floor; pages below it are never handed out
                if (page_used < page_total) begin
                    for (pg = page_floor; pg < page_total; pg++) begin
                        if (!occupied[pg]) begin
                            occupied[pg] = 1'b1;
                            page_used++;
                            granted = pg * PAGE_BYTES;
                            st = pba_pkg::ST_OK;
                            break;
                        end
                    end
                end
            end else if (kind == pba_pkg::REQ_FREE) begin
                pg = addr / PAGE_BYTES;
                if (addr == 0) begin
                    st = pba_pkg::ST_NULL_ADDR;
                end else if (pg >= page_total) begin
                    st = pba_pkg::ST_RANGE;
                end else if (!occupied[pg]) begin
                    st = pba_pkg::ST_ALREADY_FREE;
                end else begin
                    occupied[pg] = 1'b0;
                    page_used--;
                end
            end
            r.status        = st;
            r.alloc_address = granted;
            r.total_pages   = map_ready ? 16'(page_total) : 16'd0;
            r.used_pages    = map_ready ? 16'(page_used) : 16'd0;
            r.free_pages    = map_ready ? 16'(page_total - page_used) : 16'd0;
            r.ready_res     = map_ready;
            owed_q.push_back(r);
            return r;
        endfunction

        task check_result(logic [2:0] st, logic [87:0] data);
            pba_pkg::result_t want;
            if (owed_q.size() == 0) begin
                report($sformatf("result with nothing owed: status %0d", st));
                return;
            end
            want = owed_q.pop_front();
            if (st !== want.status)
                report($sformatf("status %0d, want %0d", st, want.status));
            if (data[31:0] !== want.alloc_address)
                report($sformatf("alloc_address %h, want %h", data[31:0], want.alloc_address));
            if (data[47:32] !== want.total_pages)
                report($sformatf("total_pages %0d, want %0d", data[47:32], want.total_pages));
            if (data[63:48] !== want.used_pages)
                report($sformatf("used_pages %0d, want %0d", data[63:48], want.used_pages));
            if (data[79:64] !== want.free_pages)
                report($sformatf("free_pages %0d, want %0d", data[79:64], want.free_pages));
            if (data[80] !== want.ready_res)
                report($sformatf("ready_res %b, want %b", data[80], want.ready_res));
        endtask
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [87:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data  = '0;

    page_map_scoreboard sb = new();
    logic [31:0] live_q [$];
    int          tx_idle_pct = 23;
    int          rx_idle_pct = 81;
    int          items_sent  = 0;
    int          stall_cycles = 0;

    page_bitmap_allocator #(
        .MAX_PAGES (MAX_PAGES),
        .PAGE_BYTES(PAGE_BYTES)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always begin
        @(negedge aclk);
        m_tready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= IDLE_LIMIT) begin
                $display("page_bitmap_allocator: mismatch");
                $finish;
            end
        end
    end

    // entered and left just after a falling edge
    task automatic send_req(logic [1:0] kind, logic [31:0] addr);
        pba_pkg::result_t r;
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= addr;
        do @(posedge aclk); while (!s_tready);
        r = sb.note_request(kind, addr);
        items_sent++;
        if (kind == pba_pkg::REQ_INIT && r.status == pba_pkg::ST_OK)
            live_q.delete();
        if (kind == pba_pkg::REQ_ALLOC && r.status == pba_pkg::ST_OK)
            live_q.push_back(r.alloc_address);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.owed_q.size() != 0)
            @(negedge aclk);
    endtask

    task automatic put_reg(logic idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge aclk);
    endtask

    task automatic configure(logic [31:0] mem, logic [15:0] floor_pages);
        drain();
        put_reg(pba_pkg::CFG_MEMORY_BYTES, mem);
        put_reg(pba_pkg::CFG_RESERVED_PAGES, {16'd0, floor_pages});
        cfg_valid <= 1'b0;
    endtask

    // release a page handed out earlier, sometimes at an offset inside it; allocate if none is out
    task automatic free_live();
        int unsigned idx;
        logic [31:0] addr;
        if (live_q.size() == 0) begin
            send_req(pba_pkg::REQ_ALLOC, $urandom);
        end else begin
            idx  = $urandom_range(live_q.size() - 1, 0);
            addr = live_q[idx];
            live_q.delete(idx);
            if ($urandom_range(1) == 1)
                addr = addr | $urandom_range(PAGE_BYTES - 1, 0);
            send_req(pba_pkg::REQ_FREE, addr);
        end
    endtask

    task automatic random_session();
        logic [31:0] mem;
        logic [15:0] floor_pages;
        int unsigned total;
        int unsigned roll;
        int unsigned steps;
        roll = $urandom_range(99);
        if (roll < 8)
            mem = $urandom_range(pba_pkg::MIN_MEMORY_BYTES - 1, 0);
        else if (roll < 14)
            mem = $urandom;
        else if (roll < 20)
            mem = $urandom_range(ADDR_TOP, 32'h0800_0000);
        else
            mem = pba_pkg::MIN_MEMORY_BYTES + $urandom_range(pba_pkg::MIN_MEMORY_BYTES, 0);
        total = (mem < pba_pkg::MIN_MEMORY_BYTES) ? 2048 : mem / PAGE_BYTES;
        if (total > MAX_PAGES)
            total = MAX_PAGES;
        roll = $urandom_range(99);
        // a floor close to the top fills the map after a few allocations
        if (roll < 20)
            floor_pages = 16'(total - $urandom_range(24, 0));
        else if (roll < 28)
            floor_pages = 16'($urandom_range(MAX_PAGES, 0));
        else if (roll < 32)
            floor_pages = 16'(MAX_PAGES);
        else
            floor_pages = 16'($urandom_range(96, 0));
        configure(mem, floor_pages);
        send_req(pba_pkg::REQ_INIT, $urandom);
        steps = $urandom_range(64, 16);
        repeat (steps) begin
            roll = $urandom_range(99);
            if (roll < 45)
                send_req(pba_pkg::REQ_ALLOC, $urandom);
            else if (roll < 80)
                free_live();
            else if (roll < 86)
                send_req(pba_pkg::REQ_FREE, $urandom);
            else if (roll < 90)
                send_req(pba_pkg::REQ_FREE, $urandom_range(total - 1, 0) * PAGE_BYTES
                                   + $urandom_range(PAGE_BYTES - 1, 0));
            else if (roll < 94)
                send_req(REQ_SPARE, $urandom);
            else if (roll < 96)
                send_req(pba_pkg::REQ_FREE, 32'd0);
            else if (roll < 98)
                send_req(pba_pkg::REQ_INIT, $urandom);
            else
                send_req(pba_pkg::REQ_ALLOC, $urandom);
        end
    endtask

    initial begin
        int phase;
        int target;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // nothing works before the map is built
        send_req(pba_pkg::REQ_ALLOC, 32'd0);
        send_req(pba_pkg::REQ_FREE, 32'd4096);
        send_req(REQ_SPARE, ADDR_TOP);
        configure(32'd0, 16'd0);
        send_req(pba_pkg::REQ_INIT, 32'd0);
        configure(pba_pkg::MIN_MEMORY_BYTES - 1, 16'(MAX_PAGES));
        send_req(pba_pkg::REQ_INIT, ADDR_TOP);

        // smallest legal map, no floor: page zero is handed out at address zero
        configure(pba_pkg::MIN_MEMORY_BYTES, 16'd0);
        send_req(pba_pkg::REQ_INIT, 32'd0);
        send_req(pba_pkg::REQ_ALLOC, 32'd0);
        send_req(pba_pkg::REQ_ALLOC, 32'd0);
        send_req(pba_pkg::REQ_FREE, 32'd0);
        send_req(pba_pkg::REQ_FREE, 32'd1);
        send_req(pba_pkg::REQ_FREE, 32'd2);
        send_req(pba_pkg::REQ_FREE, pba_pkg::MIN_MEMORY_BYTES);
        send_req(pba_pkg::REQ_FREE, ADDR_TOP);
        send_req(REQ_SPARE, 32'd0);

        // largest map with every page behind the floor
        configure(ADDR_TOP, 16'(MAX_PAGES));
        send_req(pba_pkg::REQ_INIT, 32'd0);
        send_req(pba_pkg::REQ_ALLOC, 32'd0);
        send_req(pba_pkg::REQ_FREE, 32'h07FF_FFFF);
        send_req(pba_pkg::REQ_ALLOC, 32'd0);
        send_req(pba_pkg::REQ_FREE, 32'h8000_0000);

        // a rejected rebuild keeps the old map
        configure(32'd4096, 16'd5);
        send_req(pba_pkg::REQ_INIT, 32'd0);
        send_req(pba_pkg::REQ_ALLOC, 32'd0);

        // one page above the floor, then full, then free under the floor
        configure(pba_pkg::MIN_MEMORY_BYTES + 32'd4095, 16'd2047);
        send_req(pba_pkg::REQ_INIT, 32'd0);
        send_req(pba_pkg::REQ_ALLOC, 32'd0);
        send_req(pba_pkg::REQ_ALLOC, 32'd0);
        send_req(pba_pkg::REQ_FREE, 32'd4096);

        for (phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 81 : 0;
            rx_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 23 : 0;
            target = items_sent + RANDOM_ITEMS / 3;
            while (items_sent < target)
                random_session();
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.owed_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.owed_q.size()));
        if (sb.errors == 0)
            $display("page_bitmap_allocator: match");
        else
            $display("page_bitmap_allocator: mismatch");
        $finish;
    end

endmodule
